FILE: design/input_event_to_pointer_key_translator_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the pointer and key translator
// Clocked property wrappers used by the translator core module.
// ----------------------------------------------------------------------------
`ifndef INPUT_EVENT_TO_POINTER_KEY_TRANSLATOR_CORE_MACROS_SVH
`define INPUT_EVENT_TO_POINTER_KEY_TRANSLATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IETP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define IETP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ietp_pkg.sv
// ----------------------------------------------------------------------------
// ietp_pkg
// Widths, codes, result and control types and the scancode table.
// ----------------------------------------------------------------------------
package ietp_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgW    = 13;
    localparam int PosW    = 12;
    localparam int NumW    = 45;
    localparam int DenW    = 32;

    // Register indexes
    localparam logic [CfgIdxW-1:0] REG_SCR_W   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_SCR_H   = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_WIN_W   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_WIN_H   = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_TITLE_H = 3'd4;

    // Raw event types and codes
    localparam logic [15:0] EV_SYNC = 16'd0;
    localparam logic [15:0] EV_KEY  = 16'd1;
    localparam logic [15:0] EV_REL  = 16'd2;
    localparam logic [15:0] EV_ABS  = 16'd3;
    localparam logic [15:0] CODE_X      = 16'd0;
    localparam logic [15:0] CODE_Y      = 16'd1;
    localparam logic [15:0] CODE_WHEEL  = 16'd8;
    localparam logic [15:0] CODE_REPORT = 16'd0;
    localparam logic [15:0] BTN_FIRST   = 16'h110;
    localparam logic [15:0] BTN_LAST    = 16'h112;
    localparam logic [15:0] BTN_RIGHT   = 16'd273;
    localparam logic [15:0] BTN_MIDDLE  = 16'd274;
    localparam logic [15:0] SCAN_DEPTH  = 16'd111;

    // Result kinds
    localparam logic [2:0] K_SCROLL   = 3'd0;
    localparam logic [2:0] K_KEYDOWN  = 3'd1;
    localparam logic [2:0] K_KEYUP    = 3'd2;
    localparam logic [2:0] K_BTNDOWN  = 3'd3;
    localparam logic [2:0] K_BTNUP    = 3'd4;
    localparam logic [2:0] K_MOVE     = 3'd5;
    localparam logic [2:0] K_CLOSE    = 3'd6;
    localparam logic [2:0] K_MAXIMIZE = 3'd7;

    // Button ids and pending edge codes
    localparam logic [1:0] BTN_NONE = 2'd0;
    localparam logic [1:0] BTN_L    = 2'd1;
    localparam logic [1:0] BTN_M    = 2'd2;
    localparam logic [1:0] BTN_R    = 2'd3;
    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_DOWN = 2'd1;
    localparam logic [1:0] EDGE_UP   = 2'd2;

    // Title bar button offsets from the right edge
    localparam int CLOSE_FAR   = 20;
    localparam int CLOSE_NEAR  = 10;
    localparam int MAX_FAR     = 38;
    localparam int MAX_NEAR    = 28;
    localparam int CLOSE2_FAR  = 56;
    localparam int CLOSE2_NEAR = 46;

    localparam logic [PosW-1:0] RESET_X = 12'd512;
    localparam logic [PosW-1:0] RESET_Y = 12'd384;
    localparam logic [CfgW-1:0] MAX_SCREEN = 13'd4096;

    typedef struct packed {
        logic [2:0]        event_kind;
        logic [7:0]        key_code;
        logic [PosW-1:0]   pos_x;
        logic [PosW-1:0]   pos_y;
        logic [1:0]        button;
        logic signed [31:0] scroll_delta;
    } t_res;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    // Screen register as used for clamping: zero acts as one, large as 4096.
    function automatic logic [CfgW-1:0] eff_screen(input logic [CfgW-1:0] s);
        logic [CfgW-1:0] r;
        begin
            if (s == '0) r = 13'd1;
            else if (s > MAX_SCREEN) r = MAX_SCREEN;
            else r = s;
            return r;
        end
    endfunction

    // Scancode to key code; zero marks an unmapped code.
    function automatic logic [7:0] scan_map(input logic [6:0] c);
        logic [7:0] k;
        begin
            case (c)
                7'd1:   k = 8'd128;
                7'd2:   k = "1";
                7'd3:   k = "2";
                7'd4:   k = "3";
                7'd5:   k = "4";
                7'd6:   k = "5";
                7'd7:   k = "6";
                7'd8:   k = "7";
                7'd9:   k = "8";
                7'd10:  k = "9";
                7'd11:  k = "0";
                7'd14:  k = 8'd132;
                7'd15:  k = 8'd130;
                7'd16:  k = "q";
                7'd17:  k = "w";
                7'd18:  k = "e";
                7'd19:  k = "r";
                7'd20:  k = "t";
                7'd21:  k = "y";
                7'd22:  k = "u";
                7'd23:  k = "i";
                7'd24:  k = "o";
                7'd25:  k = "p";
                7'd28:  k = 8'd129;
                7'd30:  k = "a";
                7'd31:  k = "s";
                7'd32:  k = "d";
                7'd33:  k = "f";
                7'd34:  k = "g";
                7'd35:  k = "h";
                7'd36:  k = "j";
                7'd37:  k = "k";
                7'd38:  k = "l";
                7'd44:  k = "z";
                7'd45:  k = "x";
                7'd46:  k = "c";
                7'd47:  k = "v";
                7'd48:  k = "b";
                7'd49:  k = "n";
                7'd50:  k = "m";
                7'd57:  k = 8'd131;
                7'd103: k = 8'd133;
                7'd105: k = 8'd135;
                7'd106: k = 8'd136;
                7'd108: k = 8'd134;
                default: k = 8'd0;
            endcase
            return k;
        end
    endfunction

endpackage

FILE: design/ietp_if.sv
// ----------------------------------------------------------------------------
// ietp interfaces
// Event input, result output and register write channels.
// ----------------------------------------------------------------------------
interface ietp_ev_if;
    logic               valid;
    logic               ready;
    logic [15:0]        ev_type;
    logic [15:0]        ev_code;
    logic signed [31:0] ev_value;
    logic signed [31:0] axis_min;
    logic signed [31:0] axis_max;
    logic               axis_info_ok;

    modport source(output valid, ev_type, ev_code, ev_value, axis_min, axis_max,
                   axis_info_ok, input ready);
    modport sink(input valid, ev_type, ev_code, ev_value, axis_min, axis_max,
                 axis_info_ok, output ready);
endinterface

interface ietp_res_if;
    logic               valid;
    logic               ready;
    logic [2:0]         event_kind;
    logic [7:0]         key_code;
    logic [11:0]        pos_x;
    logic [11:0]        pos_y;
    logic [1:0]         button;
    logic signed [31:0] scroll_delta;

    modport source(output valid, event_kind, key_code, pos_x, pos_y, button,
                   scroll_delta, input ready);
    modport sink(input valid, event_kind, key_code, pos_x, pos_y, button,
                 scroll_delta, output ready);
endinterface

interface ietp_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [12:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

FILE: design/input_event_to_pointer_key_translator_core.sv
// ----------------------------------------------------------------------------
// input_event_to_pointer_key_translator_core
// Raw input event to pointer, button, scroll and key result translator.
// ----------------------------------------------------------------------------
// Usage:
//   i_ev takes one raw event per transaction; o_res gives at most one result
//   per event; i_cfg writes the five size registers (always ready) and must
//   only be used while the block is idle.
//   An accepted event is held in an input register and handled in the next
//   cycle. Wheel, mapped key and sync report events with a pending move or
//   button edge load the result register from the decode state once it is
//   free; relative motion only moves the pointer. Absolute motion steps
//   through accept, decode, multiply, divider start and the shared serial
//   divider at one quotient bit per cycle, then an update of the pointer.
//   i_ev is ready only while no event is in work.
//   The single output register lets a new event be taken while a result
//   waits; if a second result is due while the receiver stalls, the block
//   holds that event until the register is free.
//   Reset restores the screen to 1024x768, removes the window and title bar,
//   puts the pointer at 512,384 and clears all pending marks.
// ----------------------------------------------------------------------------
`include "input_event_to_pointer_key_translator_core_macros.svh"

module input_event_to_pointer_key_translator_core (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ietp_ev_if.sink    i_ev,
    ietp_res_if.source o_res,
    ietp_cfg_if.sink   i_cfg
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_DIVS = 3'd3;
    localparam logic [2:0] S_DIVW = 3'd4;

    // Configuration registers
    logic [12:0] r_scr_w, r_scr_h, r_win_w, r_win_h, r_title_h;

    // Control and pointer state
    logic [2:0]  r_state, n_state;
    logic [11:0] r_ptr_x, n_ptr_x, r_ptr_y, n_ptr_y;
    logic        r_move, n_move;
    logic [1:0]  r_edge, n_edge, r_pbtn, n_pbtn;
    logic        r_out_valid, n_out_valid;
    ietp_pkg::t_res r_out, n_out;

    // Captured event
    logic [15:0]        r_type, r_code;
    logic signed [31:0] r_val, r_min, r_max;
    logic               r_ok;

    // Absolute scaling datapath
    logic [31:0]            r_span;
    logic [31:0]            r_diff;
    logic [12:0]            r_lim;
    logic                   r_axis_y;
    logic [44:0]            r_prod;
    ietp_pkg::t_div_ctl     div_ctl;
    ietp_pkg::t_div_sts     div_sts;
    logic [44:0]            div_quo;

    logic [12:0]        sw, sh;
    logic signed [32:0] d_diff, d_span, rel_sum;
    logic [11:0]        rel_clamped, quo_clamped;
    logic [12:0]        rel_lim;
    logic [7:0]         key;
    logic               out_free;
    logic [2:0]         win_kind;
    logic [1:0]         win_btn;
    ietp_pkg::t_res     win_res;

    assign sw = ietp_pkg::eff_screen(r_scr_w);
    assign sh = ietp_pkg::eff_screen(r_scr_h);

    assign i_ev.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign out_free    = !r_out_valid || o_res.ready;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w   <= 13'd1024;
            r_scr_h   <= 13'd768;
            r_win_w   <= '0;
            r_win_h   <= '0;
            r_title_h <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                ietp_pkg::REG_SCR_W:   r_scr_w   <= i_cfg.data;
                ietp_pkg::REG_SCR_H:   r_scr_h   <= i_cfg.data;
                ietp_pkg::REG_WIN_W:   r_win_w   <= i_cfg.data;
                ietp_pkg::REG_WIN_H:   r_win_h   <= i_cfg.data;
                ietp_pkg::REG_TITLE_H: r_title_h <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_ev.valid && i_ev.ready) begin
            r_type <= i_ev.ev_type;
            r_code <= i_ev.ev_code;
            r_val  <= i_ev.ev_value;
            r_min  <= i_ev.axis_min;
            r_max  <= i_ev.axis_max;
            r_ok   <= i_ev.axis_info_ok;
        end
    end

    // Relative motion: add and clamp to the screen
    assign rel_lim = (r_code == ietp_pkg::CODE_X) ? sw : sh;
    assign rel_sum = $signed({21'd0, (r_code == ietp_pkg::CODE_X) ? r_ptr_x : r_ptr_y})
                   + 33'(r_val);
    always_comb begin
        if (rel_sum < 0) rel_clamped = 12'd0;
        else if (rel_sum >= $signed({20'd0, rel_lim})) rel_clamped = 12'(rel_lim - 13'd1);
        else rel_clamped = rel_sum[11:0];
    end

    // Absolute motion operands
    assign d_diff = 33'(r_val) - 33'(r_min);
    assign d_span = 33'(r_max) - 33'(r_min);

    // Quotient clamped to the screen limit
    assign quo_clamped = (div_quo >= {32'd0, r_lim}) ? 12'(r_lim - 13'd1) : div_quo[11:0];

    assign key = (r_code < ietp_pkg::SCAN_DEPTH) ? ietp_pkg::scan_map(r_code[6:0]) : 8'd0;

    // Pointer result for a sync report
    assign win_kind = (r_edge == ietp_pkg::EDGE_DOWN) ? ietp_pkg::K_BTNDOWN
                    : (r_edge == ietp_pkg::EDGE_UP) ? ietp_pkg::K_BTNUP : ietp_pkg::K_MOVE;
    assign win_btn  = (r_edge != ietp_pkg::EDGE_NONE) ? r_pbtn : ietp_pkg::BTN_NONE;

    ietp_win u_win (
        .i_scr_w   (r_scr_w),
        .i_win_w   (r_win_w),
        .i_win_h   (r_win_h),
        .i_title_h (r_title_h),
        .i_scr_h   (r_scr_h),
        .i_x       (r_ptr_x),
        .i_y       (r_ptr_y),
        .i_kind    (win_kind),
        .i_btn     (win_btn),
        .o_res     (win_res)
    );

    ietp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (r_prod),
        .i_den   (r_span),
        .o_sts   (div_sts),
        .o_quo   (div_quo)
    );

    assign div_ctl.start = (r_state == S_DIVS);

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_ptr_x     = r_ptr_x;
        n_ptr_y     = r_ptr_y;
        n_move      = r_move;
        n_edge      = r_edge;
        n_pbtn      = r_pbtn;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out       = r_out;
        case (r_state)
            S_IDLE: begin
                if (i_ev.valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_type)
                    ietp_pkg::EV_REL: begin
                        if (r_code == ietp_pkg::CODE_X) begin
                            n_ptr_x = rel_clamped;
                            n_move  = 1'b1;
                        end else if (r_code == ietp_pkg::CODE_Y) begin
                            n_ptr_y = rel_clamped;
                            n_move  = 1'b1;
                        end else if (r_code == ietp_pkg::CODE_WHEEL) begin
                            if (out_free) begin
                                n_out              = '0;
                                n_out.event_kind   = ietp_pkg::K_SCROLL;
                                n_out.scroll_delta = r_val;
                                n_out_valid        = 1'b1;
                            end else begin
                                n_state = S_EXEC;
                            end
                        end
                    end
                    ietp_pkg::EV_ABS: begin
                        if ((r_code == ietp_pkg::CODE_X || r_code == ietp_pkg::CODE_Y)
                            && r_ok && (r_max > r_min)) begin
                            if (d_diff < 0) begin
                                // Negative offset truncates to zero or below: clamp to 0
                                if (r_code == ietp_pkg::CODE_X) n_ptr_x = 12'd0;
                                else n_ptr_y = 12'd0;
                                n_move = 1'b1;
                            end else begin
                                n_state = S_MUL;
                            end
                        end
                    end
                    ietp_pkg::EV_KEY: begin
                        if (r_code >= ietp_pkg::BTN_FIRST && r_code <= ietp_pkg::BTN_LAST) begin
                            n_edge = (r_val != 0) ? ietp_pkg::EDGE_DOWN : ietp_pkg::EDGE_UP;
                            n_pbtn = (r_code == ietp_pkg::BTN_RIGHT) ? ietp_pkg::BTN_R
                                   : (r_code == ietp_pkg::BTN_MIDDLE) ? ietp_pkg::BTN_M
                                   : ietp_pkg::BTN_L;
                        end else if (key != 8'd0) begin
                            if (out_free) begin
                                n_out            = '0;
                                n_out.event_kind = (r_val != 0) ? ietp_pkg::K_KEYDOWN
                                                                : ietp_pkg::K_KEYUP;
                                n_out.key_code   = key;
                                n_out_valid      = 1'b1;
                            end else begin
                                n_state = S_EXEC;
                            end
                        end
                    end
                    ietp_pkg::EV_SYNC: begin
                        if (r_code == ietp_pkg::CODE_REPORT) begin
                            if (r_edge != ietp_pkg::EDGE_NONE || r_move) begin
                                if (out_free) begin
                                    n_out       = win_res;
                                    n_out_valid = 1'b1;
                                    n_edge      = ietp_pkg::EDGE_NONE;
                                    n_pbtn      = ietp_pkg::BTN_NONE;
                                    n_move      = 1'b0;
                                end else begin
                                    n_state = S_EXEC;
                                end
                            end else begin
                                n_edge = ietp_pkg::EDGE_NONE;
                                n_pbtn = ietp_pkg::BTN_NONE;
                                n_move = 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            S_MUL:  n_state = S_DIVS;
            S_DIVS: n_state = S_DIVW;
            S_DIVW: begin
                if (div_sts.done) begin
                    if (r_axis_y) n_ptr_y = quo_clamped;
                    else n_ptr_x = quo_clamped;
                    n_move  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr_x     <= ietp_pkg::RESET_X;
            r_ptr_y     <= ietp_pkg::RESET_Y;
            r_move      <= 1'b0;
            r_edge      <= ietp_pkg::EDGE_NONE;
            r_pbtn      <= ietp_pkg::BTN_NONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr_x     <= n_ptr_x;
            r_ptr_y     <= n_ptr_y;
            r_move      <= n_move;
            r_edge      <= n_edge;
            r_pbtn      <= n_pbtn;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: result, scaling operands and product
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (r_state == S_EXEC) begin
            r_diff   <= d_diff[31:0];
            r_span   <= d_span[31:0];
            r_lim    <= rel_lim;
            r_axis_y <= (r_code == ietp_pkg::CODE_Y);
        end
        if (r_state == S_MUL) r_prod <= 45'(r_diff) * 45'(r_lim);
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.event_kind   = r_out.event_kind;
    assign o_res.key_code     = r_out.key_code;
    assign o_res.pos_x        = r_out.pos_x;
    assign o_res.pos_y        = r_out.pos_y;
    assign o_res.button       = r_out.button;
    assign o_res.scroll_delta = r_out.scroll_delta;

    // Checks on the sequencer and the shared divider
    `IETP_ASSERT_NEXT(a_accept_exec, i_ev.valid && i_ev.ready, r_state == S_EXEC,
                      "accepted event did not enter execution")
    `IETP_ASSERT_NOW(a_done_in_wait, div_sts.done, r_state == S_DIVW,
                     "divider finished outside the wait state")
    `IETP_ASSERT_NEXT(a_start_busy, div_ctl.start, div_sts.busy,
                      "divider did not start")
    `IETP_ASSERT_NOW(a_scroll_clean,
                     r_out_valid && r_out.event_kind == ietp_pkg::K_SCROLL,
                     r_out.pos_x == '0 && r_out.button == '0 && r_out.key_code == '0,
                     "scroll result carries pointer fields")
endmodule

FILE: design/ietp_div.sv
// ----------------------------------------------------------------------------
// ietp_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ietp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ietp_pkg::t_div_ctl         i_ctl,
    input  logic [ietp_pkg::NumW-1:0]  i_num,
    input  logic [ietp_pkg::DenW-1:0]  i_den,
    output ietp_pkg::t_div_sts         o_sts,
    output logic [ietp_pkg::NumW-1:0]  o_quo
);
    localparam logic [5:0] Steps = 6'(ietp_pkg::NumW);

    logic [ietp_pkg::DenW:0]    r_rem;
    logic [ietp_pkg::NumW-1:0]  r_qn;
    logic [5:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [ietp_pkg::DenW:0]    trial;
    logic                       ge;

    // Shift the next numerator bit into the partial remainder and try a subtract.
    assign trial = {r_rem[ietp_pkg::DenW-1:0], r_qn[ietp_pkg::NumW-1]};
    assign ge    = trial >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= Steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder and numerator/quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_qn  <= i_num;
        end else if (r_busy) begin
            r_rem <= ge ? (trial - {1'b0, i_den}) : trial;
            r_qn  <= {r_qn[ietp_pkg::NumW-2:0], ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_qn;
endmodule

FILE: design/ietp_win.sv
// ----------------------------------------------------------------------------
// ietp_win
// Pointer result builder: title bar hits and window translation.
// ----------------------------------------------------------------------------
module ietp_win (
    input  logic [ietp_pkg::CfgW-1:0] i_scr_w,
    input  logic [ietp_pkg::CfgW-1:0] i_win_w,
    input  logic [ietp_pkg::CfgW-1:0] i_win_h,
    input  logic [ietp_pkg::CfgW-1:0] i_title_h,
    input  logic [ietp_pkg::CfgW-1:0] i_scr_h,
    input  logic [ietp_pkg::PosW-1:0] i_x,
    input  logic [ietp_pkg::PosW-1:0] i_y,
    input  logic [2:0]                i_kind,
    input  logic [1:0]                i_btn,
    output ietp_pkg::t_res            o_res
);
    logic [12:0]        sw, sh;
    logic signed [13:0] dxs, dys;
    logic [11:0]        dx, dy;
    logic signed [14:0] rx, ry, ww, wh, th;
    logic               has_win, in_bar, hit_close, hit_max, hit_close2;
    logic [11:0]        cx, cy;

    assign sw = ietp_pkg::eff_screen(i_scr_w);
    assign sh = ietp_pkg::eff_screen(i_scr_h);

    // Centering offsets, zero when the window exceeds the screen.
    assign dxs = $signed({1'b0, sw}) - $signed({1'b0, i_win_w});
    assign dys = $signed({1'b0, sh}) - $signed({1'b0, i_win_h});
    assign dx  = dxs[13] ? 12'd0 : dxs[12:1];
    assign dy  = dys[13] ? 12'd0 : dys[12:1];

    assign ww = $signed({2'b00, i_win_w});
    assign wh = $signed({2'b00, i_win_h});
    assign th = $signed({2'b00, i_title_h});
    assign rx = $signed({3'b000, i_x}) - $signed({3'b000, dx});
    assign ry = $signed({3'b000, i_y}) - $signed({3'b000, dy});

    assign has_win = (i_win_w != '0) && (i_win_h != '0);

    // Title bar button zones, measured from the window's right edge.
    assign in_bar = (i_kind == ietp_pkg::K_BTNDOWN) && (i_btn == ietp_pkg::BTN_L)
                  && has_win && (i_title_h != '0)
                  && (rx >= 0) && (rx < ww) && (ry >= 0) && (ry < th);
    assign hit_close  = (rx >= ww - 15'(ietp_pkg::CLOSE_FAR))
                     && (rx <= ww - 15'(ietp_pkg::CLOSE_NEAR));
    assign hit_max    = (rx >= ww - 15'(ietp_pkg::MAX_FAR))
                     && (rx <= ww - 15'(ietp_pkg::MAX_NEAR));
    assign hit_close2 = (rx >= ww - 15'(ietp_pkg::CLOSE2_FAR))
                     && (rx <= ww - 15'(ietp_pkg::CLOSE2_NEAR));

    // Clamp the translated point into the window.
    always_comb begin
        if (rx < 0) cx = 12'd0;
        else if (rx >= ww) cx = 12'(i_win_w - 13'd1);
        else cx = rx[11:0];
        if (ry < 0) cy = 12'd0;
        else if (ry >= wh) cy = 12'(i_win_h - 13'd1);
        else cy = ry[11:0];
    end

    always_comb begin
        o_res = '0;
        if (in_bar && (hit_close || hit_close2)) begin
            o_res.event_kind = ietp_pkg::K_CLOSE;
        end else if (in_bar && hit_max) begin
            o_res.event_kind = ietp_pkg::K_MAXIMIZE;
        end else begin
            o_res.event_kind = i_kind;
            o_res.button     = i_btn;
            o_res.pos_x      = has_win ? cx : i_x;
            o_res.pos_y      = has_win ? cy : i_y;
        end
    end
endmodule
